// ----- rtl/scba_pkg.sv -----
`timescale 1ns / 1ps

package scba_pkg;

    // Stream widths: slave tdata = request_size, block_index; master tdata = result fields
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 88;

    typedef logic [1:0] t_class;
    typedef logic [1:0] t_status;
    typedef logic [8:0] t_link;

    // Action codes carried in the slave tuser
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Status codes carried in the master tuser
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_BLOCK = 2'd1;
    localparam t_status ST_RANGE    = 2'd2;

    // Size classes
    localparam t_class CLS_TINY   = 2'd0;
    localparam t_class CLS_SMALL  = 2'd1;
    localparam t_class CLS_MEDIUM = 2'd2;
    localparam t_class CLS_LARGE  = 2'd3;

    // Request size limits of the three smaller classes
    localparam logic [15:0] TINY_LIMIT   = 16'd4;
    localparam logic [15:0] SMALL_LIMIT  = 16'd16;
    localparam logic [15:0] MEDIUM_LIMIT = 16'd64;

    localparam t_link       LINK_NONE       = 9'd256;
    localparam logic [8:0]  COUNT_MAX       = 9'd511;
    localparam logic [9:0]  LOW_WATER_START = 10'd1000;

    localparam logic [10:0] CLASS_BYTES [4] = '{11'd4, 11'd16, 11'd64, 11'd1024};

endpackage

// ----- rtl/size_class_block_allocator_unit.sv -----
// Channel  | Direction | tdata (low bit up)                          | tuser
// ---------+-----------+---------------------------------------------+--------------
// s_axis   | in        | request_size[15:0], block_index[23:16]      | action
// m_axis   | out       | given_index, block_class, block_capacity,   | status
//          |           | data_offset, class_free_count,              |
//          |           | class_low_water, big_request_total, pad 0   |
//
// Flow: one transaction at a time, accepted only in idle. The accept cycle reads
// the link memory at the class head; the write-back state then takes the
// registered link, writes back and loads the result register.
// Reset: synchronous, active low. Link valid bits clear at once, so an unwritten
// link reads as its start-up chain value; no clearing pass, ready right away.
// Stalls: a held result does not block the next accept; the write-back cycle
// waits only while the result register is still full and not being taken.
`timescale 1ns / 1ps

module size_class_block_allocator_unit #(
    parameter int unsigned TINY_BLOCKS   = 128,
    parameter int unsigned SMALL_BLOCKS  = 64,
    parameter int unsigned MEDIUM_BLOCKS = 48,
    parameter int unsigned LARGE_BLOCKS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // request_size[15:0], block_index[23:16]
    input  logic [scba_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // action
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // given_index[7:0], block_class[9:8], block_capacity[20:10], data_offset[35:21],
    // class_free_count[44:36], class_low_water[54:45], big_request_total[86:55], zero[87]
    output logic [scba_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // status
    output logic [1:0]                      o_m_axis_tuser
);

    import scba_pkg::*;

    // Layout: classes in order, clipped so no block index passes 255
    localparam int unsigned POOL_MAX = 256;
    localparam int unsigned EFF0   = (TINY_BLOCKS < POOL_MAX) ? TINY_BLOCKS : POOL_MAX;
    localparam int unsigned FIRST1 = EFF0;
    localparam int unsigned EFF1   = (SMALL_BLOCKS < POOL_MAX - FIRST1) ?
                                     SMALL_BLOCKS : POOL_MAX - FIRST1;
    localparam int unsigned FIRST2 = FIRST1 + EFF1;
    localparam int unsigned EFF2   = (MEDIUM_BLOCKS < POOL_MAX - FIRST2) ?
                                     MEDIUM_BLOCKS : POOL_MAX - FIRST2;
    localparam int unsigned FIRST3 = FIRST2 + EFF2;
    localparam int unsigned EFF3   = (LARGE_BLOCKS < POOL_MAX - FIRST3) ?
                                     LARGE_BLOCKS : POOL_MAX - FIRST3;
    localparam int unsigned POOL   = FIRST3 + EFF3;

    localparam int unsigned BASE1 = EFF0 * 4;
    localparam int unsigned BASE2 = BASE1 + EFF1 * 16;
    localparam int unsigned BASE3 = BASE2 + EFF2 * 64;

    localparam logic [8:0] FIRST_IDX [4] = '{9'd0, 9'(FIRST1), 9'(FIRST2), 9'(FIRST3)};
    localparam logic [8:0] POOL_END      = 9'(POOL);
    localparam logic [14:0] BYTE_BASE [4] = '{15'd0, 15'(BASE1), 15'(BASE2), 15'(BASE3)};
    localparam logic [8:0] EFF_CNT   [4] = '{9'(EFF0), 9'(EFF1), 9'(EFF2), 9'(EFF3)};
    localparam t_link HEAD_INIT [4] = '{
        (EFF0 != 0) ? 9'(EFF0 - 1)   : LINK_NONE,
        (EFF1 != 0) ? 9'(FIRST2 - 1) : LINK_NONE,
        (EFF2 != 0) ? 9'(FIRST3 - 1) : LINK_NONE,
        (EFF3 != 0) ? 9'(POOL - 1)   : LINK_NONE
    };

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Class a pool index falls in
    function automatic t_class class_of(input logic [7:0] idx);
        logic [8:0] x;
        x = {1'b0, idx};
        if (x < FIRST_IDX[1]) begin
            class_of = CLS_TINY;
        end else if (x < FIRST_IDX[2]) begin
            class_of = CLS_SMALL;
        end else if (x < FIRST_IDX[3]) begin
            class_of = CLS_MEDIUM;
        end else begin
            class_of = CLS_LARGE;
        end
    endfunction

    // Start-up chain: first block of a class and anything past the pool end at none
    function automatic t_link start_link(input logic [7:0] idx);
        logic [8:0] x;
        x = {1'b0, idx};
        if (x >= POOL_END || x == FIRST_IDX[0] || x == FIRST_IDX[1] ||
            x == FIRST_IDX[2] || x == FIRST_IDX[3]) begin
            start_link = LINK_NONE;
        end else begin
            start_link = x - 9'd1;
        end
    endfunction

    // Byte offset of a block; wraps to 15 bits
    function automatic logic [14:0] offset_of(input logic [7:0] idx, input t_class c);
        logic [14:0] rel;
        rel = 15'({1'b0, idx} - FIRST_IDX[c]);
        case (c)
            CLS_TINY:   offset_of = BYTE_BASE[0] + (rel << 2);
            CLS_SMALL:  offset_of = BYTE_BASE[1] + (rel << 4);
            CLS_MEDIUM: offset_of = BYTE_BASE[2] + (rel << 6);
            default:    offset_of = BYTE_BASE[3] + (rel << 10);
        endcase
    endfunction

    // Control state
    t_state       r_state;
    logic [255:0] r_vld;
    t_link        r_head  [4];
    logic [8:0]   r_total [4];
    logic [9:0]   r_min   [4];
    logic [31:0]  r_big;
    logic         r_out_valid;

    // Link memory and its registered read port
    t_link        mem_link [256];
    t_link        r_rd_data;
    logic         r_rd_vld;

    // Per-transaction registers
    logic         r_act;
    logic         r_hit;
    logic         r_bad;
    t_class       r_cls;
    logic [7:0]   r_idx;
    t_link        r_cur_head;
    logic [8:0]   r_cur_total;
    logic [9:0]   r_cur_min;

    logic [M_TDATA_W-1:0] r_out_data;
    t_status              r_out_user;

    // Accept-side logic
    logic         s_acc;
    logic [15:0]  in_size;
    logic [7:0]   in_bidx;
    t_class       c_req;
    t_class       c_alloc;
    t_class       c_sel;
    logic [3:0]   avail;
    logic         alloc_hit;
    logic         free_bad;
    logic         rd_en;
    logic [7:0]   rd_addr;

    // Write-back logic
    logic         exec_go;
    t_link        link_val;
    logic         we;
    t_link        wdata;
    logic         upd;
    t_link        n_head;
    logic [8:0]   n_total;
    logic [9:0]   n_min;
    t_state       n_state;
    t_status      res_status;
    logic [7:0]   res_given;
    t_class       res_class;
    logic [10:0]  res_cap;
    logic [14:0]  res_off;
    logic [8:0]   res_cnt;
    logic [9:0]   res_low;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_size = i_s_axis_tdata[15:0];
    assign in_bidx = i_s_axis_tdata[23:16];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            avail[k] = (r_total[k] != 9'd0) && !r_head[k][8];
        end
        if (in_size <= TINY_LIMIT) begin
            c_req = CLS_TINY;
        end else if (in_size <= SMALL_LIMIT) begin
            c_req = CLS_SMALL;
        end else if (in_size <= MEDIUM_LIMIT) begin
            c_req = CLS_MEDIUM;
        end else begin
            c_req = CLS_LARGE;
        end
        // Fall back to a medium block when the asked class is dry
        c_alloc   = (!avail[c_req] && avail[CLS_MEDIUM]) ? CLS_MEDIUM : c_req;
        alloc_hit = avail[c_alloc];
        free_bad  = ({1'b0, in_bidx} >= POOL_END);
        if (i_s_axis_tuser == ACT_FREE) begin
            c_sel = free_bad ? CLS_TINY : class_of(in_bidx);
        end else begin
            c_sel = c_alloc;
        end
        rd_addr = r_head[c_alloc][7:0];
        rd_en   = s_acc && (i_s_axis_tuser == ACT_ALLOC) && alloc_hit;
    end

    // Link memory: read on accept, write in the write-back state, never both
    // at once, so no forwarding is needed between neighbors.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem_link[rd_addr];
        end
        if (exec_go && we) begin
            mem_link[r_idx] <= wdata;
        end
    end

    // Latch the transaction and the touched class's state
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_act       <= i_s_axis_tuser;
            r_hit       <= alloc_hit;
            r_bad       <= free_bad;
            r_cls       <= c_sel;
            r_idx       <= (i_s_axis_tuser == ACT_FREE) ? in_bidx : rd_addr;
            r_cur_head  <= r_head[c_sel];
            r_cur_total <= r_total[c_sel];
            r_cur_min   <= r_min[c_sel];
        end
    end

    assign exec_go = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        link_val   = r_rd_vld ? r_rd_data : start_link(r_idx);
        we         = 1'b0;
        wdata      = LINK_NONE;
        upd        = 1'b0;
        n_head     = r_cur_head;
        n_total    = r_cur_total;
        n_min      = r_cur_min;
        res_status = ST_OK;
        res_given  = r_idx;
        res_class  = r_cls;
        res_cap    = CLASS_BYTES[r_cls];
        res_off    = offset_of(r_idx, r_cls);
        res_cnt    = r_cur_total;
        res_low    = r_cur_min;
        if (r_act == ACT_ALLOC) begin
            if (r_hit) begin
                // Pop: head advances to the block's link, the block's link goes to none
                we      = 1'b1;
                upd     = 1'b1;
                n_head  = link_val;
                n_total = r_cur_total - 9'd1;
                n_min   = ({1'b0, n_total} < r_cur_min) ? {1'b0, n_total} : r_cur_min;
                res_cnt = n_total;
                res_low = n_min;
            end else begin
                res_status = ST_NO_BLOCK;
                res_given  = 8'd0;
                res_cap    = 11'd0;
                res_off    = 15'd0;
            end
        end else if (r_bad) begin
            res_status = ST_RANGE;
            res_class  = CLS_TINY;
            res_cap    = 11'd0;
            res_off    = 15'd0;
            res_cnt    = 9'd0;
            res_low    = 10'd0;
        end else begin
            // Push: block links to the old head and becomes the head
            we      = 1'b1;
            wdata   = r_cur_head;
            upd     = 1'b1;
            n_head  = {1'b0, r_idx};
            n_total = (r_cur_total < COUNT_MAX) ? r_cur_total + 9'd1 : r_cur_total;
            res_cnt = n_total;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = s_acc ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = exec_go ? S_IDLE : S_EXEC;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_big       <= 32'd0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_head[k]  <= HEAD_INIT[k];
                r_total[k] <= EFF_CNT[k];
                r_min[k]   <= LOW_WATER_START;
            end
        end else begin
            r_state <= n_state;
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            // Count big requests on accept, even when they fall back or fail
            if (s_acc && (i_s_axis_tuser == ACT_ALLOC) && (in_size > MEDIUM_LIMIT)) begin
                r_big <= r_big + 32'd1;
            end
            if (exec_go && we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (exec_go && upd) begin
                r_head[r_cls]  <= n_head;
                r_total[r_cls] <= n_total;
                r_min[r_cls]   <= n_min;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_user <= res_status;
            r_out_data <= {1'b0, r_big, res_low, res_cnt, res_off, res_cap,
                           res_class, res_given};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // An accepted transaction moves to write-back on the next edge
    a_acc_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_EXEC))
        else $error("accepted transaction did not reach write-back");

    // Never pop an empty class
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && (r_act == ACT_ALLOC) && r_hit) |-> (r_cur_total != 9'd0))
        else $error("pop from an empty class");

    // Write-back never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |-> (!r_out_valid || i_m_axis_tready))
        else $error("result register overwritten");

    // A good result carries a nonzero capacity
    a_ok_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_OK)) |-> (o_m_axis_tdata[20:10] != 11'd0))
        else $error("ok result with zero capacity");

    // A pop reads the head that was latched for the class
    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && (r_act == ACT_ALLOC) && r_hit) |-> (r_cur_head[7:0] == r_idx))
        else $error("pop index differs from class head");

endmodule
